// ===== design/psw_pkg.sv =====
`timescale 1ns / 1ps

package psw_pkg;

	localparam int BlockWordsDefault = 256;

	typedef enum logic [1:0] {
		K_CHAR     = 2'd0,
		K_TOKEN    = 2'd1,
		K_NUMBER   = 2'd2,
		K_BLOCKEND = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		OP_WAIT,
		OP_TOK_LOW5,
		OP_TOK_LOW4,
		OP_TOK_FOUR,
		OP_NUM_WORD,
		OP_NUM_SHIFT,
		OP_TEXT,
		OP_BLOCK
	} op_t;

	typedef enum logic [1:0] {
		L_NEVER,
		L_ALWAYS,
		L_EMPTY,
		L_DONE
	} lsel_t;

	typedef logic [3:0] uaddr_t;

	localparam uaddr_t A_WAIT  = 4'd0;
	localparam uaddr_t A_TOKV  = 4'd1;
	localparam uaddr_t A_NUMW  = 4'd2;
	localparam uaddr_t A_TEXT  = 4'd3;
	localparam uaddr_t A_TOKL  = 4'd4;
	localparam uaddr_t A_TOKN  = 4'd5;
	localparam uaddr_t A_NUMS  = 4'd6;
	localparam uaddr_t A_TOKT  = 4'd7;
	localparam uaddr_t A_END   = 4'd8;

	localparam logic [4:0] TagValue = 5'd4;

	typedef struct packed {
		op_t   op;
		lsel_t lsel;
		logic  take;
		logic  fire;
	} ctrl_t;

	typedef struct packed {
		logic   out_free;
		logic   text_empty;
		logic   text_more;
		logic   at_end;
		uaddr_t entry;
	} stat_t;

	function automatic logic [6:0] alpha(input logic [5:0] idx);
		logic [6:0] c;
		case (idx)
			6'd0:  c = 7'h20;
			6'd1:  c = 7'h72;
			6'd2:  c = 7'h74;
			6'd3:  c = 7'h6f;
			6'd4:  c = 7'h65;
			6'd5:  c = 7'h61;
			6'd6:  c = 7'h6e;
			6'd7:  c = 7'h69;
			6'd8:  c = 7'h73;
			6'd9:  c = 7'h6d;
			6'd10: c = 7'h63;
			6'd11: c = 7'h79;
			6'd12: c = 7'h6c;
			6'd13: c = 7'h67;
			6'd14: c = 7'h66;
			6'd15: c = 7'h77;
			6'd16: c = 7'h64;
			6'd17: c = 7'h76;
			6'd18: c = 7'h70;
			6'd19: c = 7'h62;
			6'd20: c = 7'h68;
			6'd21: c = 7'h78;
			6'd22: c = 7'h75;
			6'd23: c = 7'h71;
			6'd24: c = 7'h30;
			6'd25: c = 7'h31;
			6'd26: c = 7'h32;
			6'd27: c = 7'h33;
			6'd28: c = 7'h34;
			6'd29: c = 7'h35;
			6'd30: c = 7'h36;
			6'd31: c = 7'h37;
			6'd32: c = 7'h38;
			6'd33: c = 7'h39;
			6'd34: c = 7'h6a;
			6'd35: c = 7'h2d;
			6'd36: c = 7'h6b;
			6'd37: c = 7'h2e;
			6'd38: c = 7'h7a;
			6'd39: c = 7'h2f;
			6'd40: c = 7'h3b;
			6'd41: c = 7'h3a;
			6'd42: c = 7'h21;
			6'd43: c = 7'h2b;
			6'd44: c = 7'h40;
			6'd45: c = 7'h2a;
			6'd46: c = 7'h2c;
			6'd47: c = 7'h3f;
			default: c = 7'h20;
		endcase
		return c;
	endfunction

endpackage

// ===== design/packed_source_word_decoder_unit.sv =====
`timescale 1ns / 1ps
// packed source word decoder
// input channel: in_valid / in_stall carry one 32-bit source word per request;
// a request is taken when in_valid is high and in_stall is low
// output channel: out_valid / out_stall carry one result per request
// (kind, tag, char_code, number, hex_flag, last); last marks the final result
// of a word, and a word may give no result at all
// a short microprogram walks each word: one step to take the word, one step
// per result other than the block end, and a closing step (which also issues
// the block end on the last word of a block), plus one more step when a text
// step finds no characters; the first result is issued by the step after the
// take and is then held in the output register
// in_stall stays high while a word is being worked
// the output register lets the next word be taken while the last result waits
// a stall on the output holds the result and freezes any step that issues a result
// reset clears the block word count, any pending number or value, and the
// output valid; no clearing pass is needed
module packed_source_word_decoder_unit
	import psw_pkg::*;
#(
	parameter int BLOCK_WORDS = BlockWordsDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [31:0]        word,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         kind,
	output logic [4:0]         tag,
	output logic [6:0]         char_code,
	output logic signed [31:0] number,
	output logic               hex_flag,
	output logic               last
);

	ctrl_t ctl;
	stat_t st;
	logic  busy;

	psw_useq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.st       (st),
		.ctl      (ctl),
		.busy     (busy)
	);

	psw_dpath #(
		.BLOCK_WORDS (BLOCK_WORDS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.word      (word),
		.ctl       (ctl),
		.st        (st),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.tag       (tag),
		.char_code (char_code),
		.number    (number),
		.hex_flag  (hex_flag),
		.last      (last)
	);

	assign in_stall = busy;

endmodule

// ===== design/psw_useq.sv =====
`timescale 1ns / 1ps

module psw_useq
	import psw_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  stat_t st,
	output ctrl_t ctl,
	output logic  busy
);

	typedef struct packed {
		op_t    op;
		lsel_t  lsel;
		uaddr_t nxt;
	} uinstr_t;

	function automatic uinstr_t rom(input uaddr_t a);
		uinstr_t u;
		unique case (a)
			A_WAIT: u = '{OP_WAIT,      L_NEVER,  A_WAIT};
			A_TOKV: u = '{OP_TOK_FOUR,  L_NEVER,  A_NUMW};
			A_NUMW: u = '{OP_NUM_WORD,  L_ALWAYS, A_END};
			A_TEXT: u = '{OP_TEXT,      L_DONE,   A_END};
			A_TOKL: u = '{OP_TOK_LOW5,  L_ALWAYS, A_END};
			A_TOKN: u = '{OP_TOK_LOW5,  L_NEVER,  A_NUMS};
			A_NUMS: u = '{OP_NUM_SHIFT, L_ALWAYS, A_END};
			A_TOKT: u = '{OP_TOK_LOW4,  L_EMPTY,  A_TEXT};
			A_END:  u = '{OP_BLOCK,     L_ALWAYS, A_WAIT};
			default: u = '{OP_WAIT,     L_NEVER,  A_WAIT};
		endcase
		return u;
	endfunction

	uaddr_t  pc_q;
	uaddr_t  pc_d;
	uinstr_t ui;

	always_comb begin
		ui       = rom(pc_q);
		ctl.op   = ui.op;
		ctl.lsel = ui.lsel;
		ctl.take = 1'b0;
		ctl.fire = 1'b0;
		pc_d     = pc_q;
		unique case (ui.op)
			OP_WAIT: begin
				if (in_valid) begin
					ctl.take = 1'b1;
					pc_d     = st.entry;
				end
			end
			OP_TEXT: begin
				if (st.text_empty) begin
					pc_d = ui.nxt;
				end else if (st.out_free) begin
					ctl.fire = 1'b1;
					if (!st.text_more) pc_d = ui.nxt;
				end
			end
			OP_BLOCK: begin
				if (!st.at_end) begin
					pc_d = ui.nxt;
				end else if (st.out_free) begin
					ctl.fire = 1'b1;
					pc_d     = ui.nxt;
				end
			end
			default: begin
				if (st.out_free) begin
					ctl.fire = 1'b1;
					pc_d     = ui.nxt;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= A_WAIT;
		end else begin
			pc_q <= pc_d;
		end
	end

	assign busy = (pc_q != A_WAIT);

	a_fire_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fire |-> st.out_free)
		else $error("result issued with output register full");

	a_take_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.take |=> pc_q != A_WAIT)
		else $error("request taken but sequencer stayed waiting");

	a_text_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.fire && ctl.op == OP_TEXT) |-> !st.text_empty)
		else $error("character issued from empty text");

endmodule

// ===== design/psw_dpath.sv =====
`timescale 1ns / 1ps

module psw_dpath
	import psw_pkg::*;
#(
	parameter int BLOCK_WORDS = BlockWordsDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [31:0]        word,
	input  ctrl_t              ctl,
	output stat_t              st,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         kind,
	output logic [4:0]         tag,
	output logic [6:0]         char_code,
	output logic signed [31:0] number,
	output logic               hex_flag,
	output logic               last
);

	localparam int CW = (BLOCK_WORDS > 2) ? $clog2(BLOCK_WORDS) : 1;

	typedef enum logic [1:0] {
		P_NONE,
		P_NUMBER,
		P_VALUE
	} pend_t;

	logic [31:0] word_q;
	logic [31:0] bits_q;
	logic [2:0]  nchar_q;
	logic        hex_q;
	logic        at_end_q;
	pend_t       pend_q;
	logic        pend_hex_q;
	logic [CW-1:0] wib_q;

	logic        at_end;
	logic [3:0]  wtag;
	uaddr_t      entry;
	logic [5:0]  idx;
	logic [2:0]  sh;
	logic [31:0] bits_nx;
	logic        text_more;
	logic        last_d;

	logic        val_q;
	kind_t       kind_q;
	logic [4:0]  tag_q;
	logic [6:0]  char_q;
	logic [31:0] num_q;
	logic        hexo_q;
	logic        last_q;

	assign at_end = (wib_q == CW'(BLOCK_WORDS - 1));
	assign wtag   = word[3:0];

	always_comb begin
		unique case (pend_q)
			P_NUMBER: entry = A_NUMW;
			P_VALUE:  entry = A_TOKV;
			default: begin
				case (wtag)
					4'd0:                entry = A_TEXT;
					4'd2, 4'd5:          entry = A_TOKL;
					4'd6, 4'd8, 4'd15:   entry = A_TOKN;
					default:             entry = A_TOKT;
				endcase
			end
		endcase
	end

	// packed text: 4, 5 or 7 bit codes from the top of the word
	always_comb begin
		if (!bits_q[31]) begin
			idx = {2'b00, bits_q[31:28]};
			sh  = 3'd4;
		end else if (!bits_q[30]) begin
			idx = 6'd8 + {3'b000, bits_q[29:27]};
			sh  = 3'd5;
		end else begin
			idx = {3'd2 + {1'b0, bits_q[29:28]}, bits_q[27:25]};
			sh  = 3'd7;
		end
		bits_nx   = bits_q << sh;
		text_more = (bits_nx != 32'd0) && (nchar_q != 3'd6);
	end

	always_comb begin
		case (ctl.lsel)
			L_ALWAYS: last_d = !at_end_q;
			L_EMPTY:  last_d = !at_end_q && (bits_q == 32'd0);
			L_DONE:   last_d = !at_end_q && !text_more;
			default:  last_d = 1'b0;
		endcase
		if (ctl.op == OP_BLOCK) last_d = 1'b1;
	end

	assign st.out_free   = !val_q || !out_stall;
	assign st.text_empty = (bits_q == 32'd0);
	assign st.text_more  = text_more;
	assign st.at_end     = at_end_q;
	assign st.entry      = entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= P_NONE;
			pend_hex_q <= 1'b0;
			wib_q      <= '0;
			val_q      <= 1'b0;
		end else begin
			if (ctl.take) begin
				wib_q <= at_end ? '0 : wib_q + CW'(1);
				if (pend_q != P_NONE) begin
					pend_q     <= P_NONE;
					pend_hex_q <= 1'b0;
				end else if ((wtag == 4'd2 || wtag == 4'd5) && !at_end) begin
					pend_q     <= P_NUMBER;
					pend_hex_q <= word[4];
				end else if (wtag == 4'd12 && !at_end) begin
					pend_q     <= P_VALUE;
					pend_hex_q <= 1'b0;
				end
			end
			if (ctl.fire) begin
				val_q <= 1'b1;
			end else if (!out_stall) begin
				val_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			word_q   <= word;
			bits_q   <= {word[31:4], 4'b0000};
			nchar_q  <= 3'd0;
			at_end_q <= at_end;
			if (pend_q == P_NUMBER) begin
				hex_q <= pend_hex_q;
			end else if (pend_q == P_VALUE) begin
				hex_q <= 1'b0;
			end else begin
				hex_q <= word[4];
			end
		end
		if (ctl.fire && ctl.op == OP_TEXT) begin
			bits_q  <= bits_nx;
			nchar_q <= nchar_q + 3'd1;
		end
		if (ctl.fire) begin
			kind_q <= K_CHAR;
			tag_q  <= 5'd0;
			char_q <= 7'd0;
			num_q  <= 32'd0;
			hexo_q <= 1'b0;
			last_q <= last_d;
			case (ctl.op)
				OP_TOK_LOW5: begin
					kind_q <= K_TOKEN;
					tag_q  <= word_q[4:0];
				end
				OP_TOK_LOW4: begin
					kind_q <= K_TOKEN;
					tag_q  <= {1'b0, word_q[3:0]};
				end
				OP_TOK_FOUR: begin
					kind_q <= K_TOKEN;
					tag_q  <= TagValue;
				end
				OP_NUM_WORD: begin
					kind_q <= K_NUMBER;
					num_q  <= word_q;
					hexo_q <= hex_q;
				end
				OP_NUM_SHIFT: begin
					kind_q <= K_NUMBER;
					num_q  <= {{5{word_q[31]}}, word_q[31:5]};
					hexo_q <= hex_q;
				end
				OP_TEXT: begin
					char_q <= alpha(idx);
				end
				OP_BLOCK: begin
					kind_q <= K_BLOCKEND;
				end
				default: begin
					kind_q <= K_CHAR;
				end
			endcase
		end
	end

	assign out_valid = val_q;
	assign kind      = kind_q;
	assign tag       = tag_q;
	assign char_code = char_q;
	assign number    = $signed(num_q);
	assign hex_flag  = hexo_q;
	assign last      = last_q;

endmodule
